// ===== rtl/hntd_pkg.sv =====
package hntd_pkg;

    // fixed geometry of the lookup tables
    localparam int ENTRIES_PER_TABLE = 16;
    localparam int WINDOW_BITS       = 4;
    localparam int TABLE_SEL_BITS    = 4;

    // payload field widths
    localparam int CMD_W    = 2;
    localparam int SEL_W    = 4;
    localparam int LINK_W   = 4;
    localparam int SYM_IN_W = 24;
    localparam int LEN_W    = 5;

    // packed stream widths
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 32;

    // parameter defaults
    localparam int DEF_TABLE_COUNT   = 16;
    localparam int DEF_MAX_CODE_BITS = 16;
    localparam int DEF_SYMBOL_BITS   = 24;

    // largest level count kept by the decoder
    localparam int LEVEL_LIMIT = 28;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BIT   = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

endpackage

// ===== rtl/huffman_nibble_table_decoder_top.sv =====
// Huffman decoder built from linked 16-entry tables, each indexed by a 4-bit
// window of the compressed stream. Every input item carries a command on
// s_axis_tuser: load writes one table entry (a symbol with its full codeword
// length, or a link to a sub-table), bit shifts one stream bit into the
// window (first bit most significant), flush drains the leftover bits as
// zero-padded windows and returns to the root table; the unused code does
// nothing. A symbol hit sends one result item and drops (length - levels
// already consumed, at least 1) bits from the window; a link moves to the
// sub-table, clears the window and adds 4 to the levels consumed (held at
// LEVEL_CAP); during a flush a link ends the flush. tlast marks the final
// result of one input item. A load, an unused command, an empty flush and a
// stream bit that leaves the window short are taken in S_IDLE. A stream bit
// that fills the window goes through S_LOOK (a table read on the registered
// read port) and S_EVAL (the shared lookup/drop unit), then back to S_IDLE.
// A flush runs S_LOOK and S_EVAL per lookup, at most three lookups, then
// S_FIN. Loads of tables at or beyond TABLE_COUNT are dropped; entries never
// loaded read back as anything. A result stalls while the last waits on tready.
module huffman_nibble_table_decoder_top #(
    parameter int TABLE_COUNT   = hntd_pkg::DEF_TABLE_COUNT,
    parameter int MAX_CODE_BITS = hntd_pkg::DEF_MAX_CODE_BITS,
    parameter int SYMBOL_BITS   = hntd_pkg::DEF_SYMBOL_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // table_sel[3:0], entry_sel[7:4], entry_is_symbol[8], entry_link[12:9],
    // entry_symbol[36:13], entry_length[41:37], stream_bit[42], zero fill
    input  logic [hntd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // command[1:0]
    input  logic [hntd_pkg::CMD_W-1:0]        s_axis_tuser,
    // result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // symbol_value[23:0], code_length[28:24], zero fill
    output logic [hntd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                              m_axis_tlast
);
    import hntd_pkg::*;

    // only 16 tables can be named by a 4-bit table number or link
    localparam int TABLES_USED = (TABLE_COUNT < 16) ? TABLE_COUNT : 16;
    localparam int DEPTH       = TABLES_USED * ENTRIES_PER_TABLE;
    localparam int ADDR_W      = $clog2(DEPTH);
    // stored symbol bits that can reach the 24-bit result
    localparam int SYM_KEEP    = (SYMBOL_BITS < SYM_IN_W) ? SYMBOL_BITS : SYM_IN_W;
    localparam int LEVEL_RAW   = (MAX_CODE_BITS / 4) * 4;
    localparam int LEVEL_CAP   = (LEVEL_RAW > LEVEL_LIMIT) ? LEVEL_LIMIT : LEVEL_RAW;
    localparam logic [TABLE_SEL_BITS:0] TABLE_LIM = (TABLE_SEL_BITS+1)'(TABLES_USED);

    typedef struct packed {
        logic                is_sym;
        logic [LINK_W-1:0]   link;
        logic [SYM_KEEP-1:0] sym;
        logic [LEN_W-1:0]    len;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,   // ready for the next item
        S_LOOK,   // table read in flight
        S_EVAL,   // symbol or link decision on the read entry
        S_FIN     // end of flush, last pending result goes out
    } t_state;

    // unpack the input item
    t_cmd                     in_cmd;
    logic [SEL_W-1:0]         in_table;
    logic [SEL_W-1:0]         in_entry;
    logic                     in_is_sym;
    logic [LINK_W-1:0]        in_link;
    logic [SYM_IN_W-1:0]      in_sym;
    logic [LEN_W-1:0]         in_len;
    logic                     in_bit;

    assign in_cmd    = t_cmd'(s_axis_tuser);
    assign in_table  = s_axis_tdata[3:0];
    assign in_entry  = s_axis_tdata[7:4];
    assign in_is_sym = s_axis_tdata[8];
    assign in_link   = s_axis_tdata[12:9];
    assign in_sym    = s_axis_tdata[36:13];
    assign in_len    = s_axis_tdata[41:37];
    assign in_bit    = s_axis_tdata[42];

    // entry store, no reset: entries are undefined until loaded
    t_entry r_mem [DEPTH];
    t_entry r_rd;

    // control state
    t_state                   r_state, n_state;
    logic [WINDOW_BITS-1:0]   r_win, n_win;
    logic [2:0]               r_cnt, n_cnt;
    logic [LINK_W-1:0]        r_tbl, n_tbl;
    logic [LEN_W-1:0]         r_lvl, n_lvl;
    logic                     r_flush, n_flush;
    logic                     r_rd_ok, n_rd_ok;
    logic                     r_out_v, n_out_v;
    logic                     r_pend_v, n_pend_v;

    // result payload
    logic [SYM_IN_W-1:0]      r_out_sym, n_out_sym;
    logic [LEN_W-1:0]         r_out_len, n_out_len;
    logic                     r_out_last, n_out_last;
    logic [SYM_IN_W-1:0]      r_pend_sym, n_pend_sym;
    logic [LEN_W-1:0]         r_pend_len, n_pend_len;

    logic                     in_acc;
    logic                     wr_ok;
    logic [ADDR_W-1:0]        wr_addr;
    logic [WINDOW_BITS-1:0]   lk_idx;
    logic [ADDR_W-1:0]        lk_addr;

    // shared lookup/drop unit
    logic                     hit_sym;
    logic [LINK_W-1:0]        hit_link;
    logic [LEN_W-1:0]         drop;
    logic                     drop_all;
    logic [2:0]               cnt_left;
    logic [WINDOW_BITS-1:0]   win_left;
    logic                     lvl_grow;
    logic                     out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign wr_ok   = ({1'b0, in_table} < TABLE_LIM);
    assign wr_addr = ADDR_W'({in_table, in_entry});

    // zero-padded window: bits present sit at the top
    assign lk_idx  = WINDOW_BITS'(r_win << (3'd4 - r_cnt));
    assign lk_addr = ADDR_W'({r_tbl, lk_idx});

    // a table beyond the store reads as a link to the root
    assign hit_sym  = r_rd_ok && r_rd.is_sym;
    assign hit_link = r_rd_ok ? r_rd.link : '0;
    assign drop     = (r_rd.len > r_lvl) ? (r_rd.len - r_lvl) : LEN_W'(1);
    assign drop_all = (drop >= {2'b00, r_cnt});
    assign cnt_left = r_cnt - 3'(drop);
    assign lvl_grow = (({1'b0, r_lvl} + 6'd4) <= 6'(LEVEL_CAP));
    assign out_free = !r_out_v || m_axis_tready;

    always_comb begin
        for (int i = 0; i < WINDOW_BITS; i++) begin
            win_left[i] = r_win[i] && (3'(i) < cnt_left);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_win      = r_win;
        n_cnt      = r_cnt;
        n_tbl      = r_tbl;
        n_lvl      = r_lvl;
        n_flush    = r_flush;
        n_rd_ok    = r_rd_ok;
        n_out_v    = r_out_v;
        n_pend_v   = r_pend_v;
        n_out_sym  = r_out_sym;
        n_out_len  = r_out_len;
        n_out_last = r_out_last;
        n_pend_sym = r_pend_sym;
        n_pend_len = r_pend_len;

        if (r_out_v && m_axis_tready) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (in_cmd)
                        CMD_BIT: begin
                            n_win   = {r_win[WINDOW_BITS-2:0], in_bit};
                            n_cnt   = r_cnt + 3'd1;
                            n_flush = 1'b0;
                            if (r_cnt == 3'(WINDOW_BITS - 1)) begin
                                n_state = S_LOOK;
                            end
                        end
                        CMD_FLUSH: begin
                            n_flush = 1'b1;
                            if (r_cnt == 3'd0) begin
                                n_tbl = '0;
                                n_lvl = '0;
                            end else begin
                                n_state = S_LOOK;
                            end
                        end
                        default: begin
                            // loads go to the store, the unused code is dropped
                        end
                    endcase
                end
            end
            S_LOOK: begin
                n_rd_ok = ({1'b0, r_tbl} < TABLE_LIM);
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (hit_sym) begin
                    if (!r_flush) begin
                        // single result, wait for the output register
                        if (out_free) begin
                            n_out_v    = 1'b1;
                            n_out_sym  = SYM_IN_W'(r_rd.sym);
                            n_out_len  = r_rd.len;
                            n_out_last = 1'b1;
                            n_win      = drop_all ? '0 : win_left;
                            n_cnt      = drop_all ? 3'd0 : cnt_left;
                            n_tbl      = '0;
                            n_lvl      = '0;
                            n_state    = S_IDLE;
                        end
                    end else if (!r_pend_v || out_free) begin
                        // flush: hold each symbol until the next one shows up,
                        // so the final one can carry tlast
                        if (r_pend_v) begin
                            n_out_v    = 1'b1;
                            n_out_sym  = r_pend_sym;
                            n_out_len  = r_pend_len;
                            n_out_last = 1'b0;
                        end
                        n_pend_v   = 1'b1;
                        n_pend_sym = SYM_IN_W'(r_rd.sym);
                        n_pend_len = r_rd.len;
                        n_win      = drop_all ? '0 : win_left;
                        n_cnt      = drop_all ? 3'd0 : cnt_left;
                        n_tbl      = '0;
                        n_lvl      = '0;
                        n_state    = drop_all ? S_FIN : S_LOOK;
                    end
                end else begin
                    n_win = '0;
                    n_cnt = 3'd0;
                    if (r_flush) begin
                        n_state = S_FIN;
                    end else begin
                        n_tbl   = hit_link;
                        n_lvl   = lvl_grow ? (r_lvl + LEN_W'(4)) : r_lvl;
                        n_state = S_IDLE;
                    end
                end
            end
            S_FIN: begin
                n_win = '0;
                n_cnt = 3'd0;
                n_tbl = '0;
                n_lvl = '0;
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_v    = 1'b1;
                    n_out_sym  = r_pend_sym;
                    n_out_len  = r_pend_len;
                    n_out_last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // table store: one write port for loads, one registered read port
    always_ff @(posedge i_clk) begin
        if (in_acc && (in_cmd == CMD_LOAD) && wr_ok) begin
            r_mem[wr_addr] <= '{is_sym: in_is_sym, link: in_link,
                                sym: SYM_KEEP'(in_sym), len: in_len};
        end
        if (r_state == S_LOOK) begin
            r_rd <= r_mem[lk_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_sym  <= n_out_sym;
        r_out_len  <= n_out_len;
        r_out_last <= n_out_last;
        r_pend_sym <= n_pend_sym;
        r_pend_len <= n_pend_len;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_win    <= '0;
            r_cnt    <= 3'd0;
            r_tbl    <= '0;
            r_lvl    <= '0;
            r_flush  <= 1'b0;
            r_rd_ok  <= 1'b0;
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_win    <= n_win;
            r_cnt    <= n_cnt;
            r_tbl    <= n_tbl;
            r_lvl    <= n_lvl;
            r_flush  <= n_flush;
            r_rd_ok  <= n_rd_ok;
            r_out_v  <= n_out_v;
            r_pend_v <= n_pend_v;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {3'b000, r_out_len, r_out_sym};
    assign m_axis_tlast  = r_out_last;

endmodule
